### hdl/fqrl_pkg.sv
// Shared types and constants for the FASTQ record locator.
`timescale 1ns / 1ps

package fqrl_pkg;

  localparam int POS_W  = 32;
  localparam int BASE_W = 31;

  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;

  // valid bit indexes for stored positions
  localparam int VX_HS = 0;
  localparam int VX_HE = 1;
  localparam int VX_SS = 2;
  localparam int VX_SE = 3;
  localparam int VX_QS = 4;
  localparam int VX_N  = 5;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    PH_HEAD_SEARCH,
    PH_HEAD_OPEN,
    PH_SEQ_FIRST,
    PH_SEQ_OPEN,
    PH_QHEAD_OPEN,
    PH_QUAL_WAIT,
    PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_COMPLETE       = 4'd0,
    ST_NO_HEADER      = 4'd1,
    ST_HEADER_OPEN    = 4'd2,
    ST_SEQ_OPEN       = 4'd4,
    ST_NO_QUAL_HEADER = 4'd5,
    ST_QUAL_SHORT     = 4'd7,
    ST_INVALID        = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } item_t;

  typedef struct packed {
    status_e status;
    pos_t    hs;
    pos_t    he;
    pos_t    ss;
    pos_t    se;
    pos_t    qs;
    pos_t    qe;
  } result_t;

endpackage

### hdl/fqrl_scan.sv
// Byte-at-a-time record scanner: scan state, position tracking and result build.
`timescale 1ns / 1ps

module fqrl_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  fqrl_pkg::item_t              item_i,
  input  logic [fqrl_pkg::BASE_W-1:0]  base_i,
  output logic                         emit_o,
  output fqrl_pkg::result_t            result_o
);

  fqrl_pkg::phase_e              phase_q, phase_d, eff_phase, adv_phase;
  logic                          prev_nl_q, prev_nl_d, eff_prev;
  logic [fqrl_pkg::VX_N-1:0]     val_q, val_d, eff_val;
  fqrl_pkg::pos_t                byte_pos_q, byte_pos_d, p;
  fqrl_pkg::pos_t                hs_q, hs_d, he_q, he_d, ss_q, ss_d;
  fqrl_pkg::pos_t                se_q, se_d, qs_q, qs_d, qe_q, qe_d;
  fqrl_pkg::pos_t                hdr_len_q, hdr_len_d, seq_len_q, seq_len_d;
  fqrl_pkg::pos_t                qhl, qhl_m1;
  fqrl_pkg::status_e             status;
  logic                          is_nl, is_at, is_plus, qhl_bad, qual_hit, last;

  assign last    = item_i.last;
  assign is_nl   = (item_i.data == fqrl_pkg::CHAR_NL);
  assign is_at   = (item_i.data == fqrl_pkg::CHAR_AT);
  assign is_plus = (item_i.data == fqrl_pkg::CHAR_PLUS);

  assign eff_phase = item_i.first ? fqrl_pkg::PH_HEAD_SEARCH : phase_q;
  assign eff_prev  = item_i.first ? 1'b0 : prev_nl_q;
  assign eff_val   = item_i.first ? '0 : val_q;

  assign p          = item_i.first ? fqrl_pkg::POS_W'(base_i) : byte_pos_q;
  assign byte_pos_d = p + fqrl_pkg::POS_W'(1);

  // quality header line length check: "+" alone or same length as header line
  assign qhl      = p - se_q;
  assign qhl_m1   = qhl - fqrl_pkg::POS_W'(1);
  assign qhl_bad  = (qhl_m1 > fqrl_pkg::POS_W'(1)) && (qhl != hdr_len_q);
  assign qual_hit = ((p - fqrl_pkg::POS_W'(2)) == qe_q);

  // next state
  always_comb begin
    adv_phase = eff_phase;
    prev_nl_d = eff_prev;
    val_d     = eff_val;
    hs_d      = hs_q;
    he_d      = he_q;
    ss_d      = ss_q;
    se_d      = se_q;
    qs_d      = qs_q;
    qe_d      = qe_q;
    hdr_len_d = hdr_len_q;
    seq_len_d = seq_len_q;
    case (eff_phase)
      fqrl_pkg::PH_HEAD_SEARCH: begin
        if (eff_prev && is_at) begin
          hs_d                  = p;
          val_d[fqrl_pkg::VX_HS] = 1'b1;
          adv_phase             = fqrl_pkg::PH_HEAD_OPEN;
        end
        prev_nl_d = is_nl;
      end
      fqrl_pkg::PH_HEAD_OPEN: begin
        if (is_nl && !last) begin
          he_d                   = p;
          ss_d                   = p + fqrl_pkg::POS_W'(1);
          hdr_len_d              = p - hs_q + fqrl_pkg::POS_W'(1);
          val_d[fqrl_pkg::VX_HE] = 1'b1;
          val_d[fqrl_pkg::VX_SS] = 1'b1;
          adv_phase              = fqrl_pkg::PH_SEQ_FIRST;
        end
      end
      fqrl_pkg::PH_SEQ_FIRST: begin
        prev_nl_d = 1'b0;
        adv_phase = fqrl_pkg::PH_SEQ_OPEN;
      end
      fqrl_pkg::PH_SEQ_OPEN: begin
        if (eff_prev && is_plus) begin
          se_d                   = p - fqrl_pkg::POS_W'(1);
          seq_len_d              = p - fqrl_pkg::POS_W'(1) - he_q;
          val_d[fqrl_pkg::VX_SE] = 1'b1;
          adv_phase              = fqrl_pkg::PH_QHEAD_OPEN;
        end
        prev_nl_d = is_nl;
      end
      fqrl_pkg::PH_QHEAD_OPEN: begin
        if (is_nl && !last && !qhl_bad) begin
          qs_d                   = p + fqrl_pkg::POS_W'(1);
          qe_d                   = p + seq_len_q;
          val_d[fqrl_pkg::VX_QS] = 1'b1;
          adv_phase              = fqrl_pkg::PH_QUAL_WAIT;
        end
      end
      default: ;
    endcase
  end

  // result emission
  always_comb begin
    emit_o = 1'b0;
    status = fqrl_pkg::ST_NO_HEADER;
    if (fire_i && (eff_phase != fqrl_pkg::PH_DONE)) begin
      if ((eff_phase == fqrl_pkg::PH_QHEAD_OPEN) && is_nl && !last && qhl_bad) begin
        emit_o = 1'b1;
        status = fqrl_pkg::ST_INVALID;
      end else if ((eff_phase == fqrl_pkg::PH_QUAL_WAIT) && qual_hit) begin
        emit_o = 1'b1;
        status = fqrl_pkg::ST_COMPLETE;
      end else if (last) begin
        emit_o = 1'b1;
        case (adv_phase)
          fqrl_pkg::PH_HEAD_SEARCH: status = fqrl_pkg::ST_NO_HEADER;
          fqrl_pkg::PH_HEAD_OPEN:   status = fqrl_pkg::ST_HEADER_OPEN;
          fqrl_pkg::PH_SEQ_FIRST:   status = fqrl_pkg::ST_SEQ_OPEN;
          fqrl_pkg::PH_SEQ_OPEN:    status = fqrl_pkg::ST_SEQ_OPEN;
          fqrl_pkg::PH_QHEAD_OPEN:  status = fqrl_pkg::ST_NO_QUAL_HEADER;
          default:                  status = fqrl_pkg::ST_QUAL_SHORT;
        endcase
      end
    end
  end

  always_comb begin
    result_o.status = status;
    result_o.hs     = val_d[fqrl_pkg::VX_HS] ? hs_d : '1;
    result_o.he     = val_d[fqrl_pkg::VX_HE] ? he_d : '1;
    result_o.ss     = val_d[fqrl_pkg::VX_SS] ? ss_d : '1;
    result_o.se     = val_d[fqrl_pkg::VX_SE] ? se_d : '1;
    result_o.qs     = val_d[fqrl_pkg::VX_QS] ? qs_d : '1;
    result_o.qe     = (status == fqrl_pkg::ST_COMPLETE) ? qe_q : '1;
  end

  assign phase_d = emit_o ? fqrl_pkg::PH_DONE : adv_phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= fqrl_pkg::PH_HEAD_SEARCH;
      prev_nl_q  <= 1'b0;
      val_q      <= '0;
      byte_pos_q <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      prev_nl_q  <= prev_nl_d;
      val_q      <= val_d;
      byte_pos_q <= byte_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hs_q      <= hs_d;
      he_q      <= he_d;
      ss_q      <= ss_d;
      se_q      <= se_d;
      qs_q      <= qs_d;
      qe_q      <= qe_d;
      hdr_len_q <= hdr_len_d;
      seq_len_q <= seq_len_d;
    end
  end

endmodule

### hdl/fastq_record_locator_core.sv
// Top level of the FASTQ record locator: input register, scanner and result register.
// Throughput: one byte per cycle, sustained while the result side does not stall.
// A result is on the output port right after the edge at which its byte
// leaves the input register.
// Rate is set by the single scan step between the input and result registers.
// Reset (asynchronous, active low) clears the scan state, position counter,
// base offset and both handshake stages.
`timescale 1ns / 1ps

module fastq_record_locator_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               first_byte_i,
  input  logic                               last_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [3:0]                         status_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  header_start_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  header_end_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  sequence_start_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  sequence_end_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  quality_start_o,
  output logic signed [fqrl_pkg::POS_W-1:0]  quality_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fqrl_pkg::BASE_W-1:0]        base_offset_i
);

  logic                          s1_valid_q, s1_valid_d, in_accept, fire, emit;
  fqrl_pkg::item_t               s1_item_q;
  logic                          out_valid_q, out_valid_d;
  fqrl_pkg::result_t             out_res_q, scan_res;
  logic [fqrl_pkg::BASE_W-1:0]   base_q;

  assign cfg_ready_o = 1'b1;

  assign fire       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !fire);

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_q <= base_offset_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q.data  <= data_byte_i;
      s1_item_q.first <= first_byte_i;
      s1_item_q.last  <= last_byte_i;
    end
    if (fire && emit) begin
      out_res_q <= scan_res;
    end
  end

  fqrl_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .base_i   (base_q),
    .emit_o   (emit),
    .result_o (scan_res)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = 4'(out_res_q.status);
  assign header_start_o   = out_res_q.hs;
  assign header_end_o     = out_res_q.he;
  assign sequence_start_o = out_res_q.ss;
  assign sequence_end_o   = out_res_q.se;
  assign quality_start_o  = out_res_q.qs;
  assign quality_end_o    = out_res_q.qe;

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_valid_q)
    else $error("emitted result not presented");

  a_qe_only_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_res_q.status != fqrl_pkg::ST_COMPLETE)) |-> (out_res_q.qe == '1))
    else $error("quality end set on incomplete record");

  a_no_fire_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("scan advanced while result register held");
`endif

endmodule

### bench/fqrl_record_checker.sv
// Checker for the FASTQ record locator: tracks transactions, predicts records and compares.
`timescale 1ns / 1ps

module fqrl_record_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_byte_i,
  input  logic                          last_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [3:0]                    status_i,
  input  logic [fqrl_pkg::POS_W-1:0]    header_start_i,
  input  logic [fqrl_pkg::POS_W-1:0]    header_end_i,
  input  logic [fqrl_pkg::POS_W-1:0]    sequence_start_i,
  input  logic [fqrl_pkg::POS_W-1:0]    sequence_end_i,
  input  logic [fqrl_pkg::POS_W-1:0]    quality_start_i,
  input  logic [fqrl_pkg::POS_W-1:0]    quality_end_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fqrl_pkg::BASE_W-1:0]   base_offset_i,
  output int                            mismatches_o,
  output int                            pending_o,
  output int                            scanned_o
);

  logic [fqrl_pkg::BASE_W-1:0]  base_q;
  fqrl_pkg::phase_e             scan_phase;
  logic                         prev_nl;
  fqrl_pkg::pos_t               next_pos;
  fqrl_pkg::pos_t               marks [fqrl_pkg::VX_N];
  logic [fqrl_pkg::VX_N-1:0]    mark_set;
  fqrl_pkg::pos_t               qhead_len;
  logic                         record_given;
  fqrl_pkg::result_t            expected_records [$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $time, field, got, want);
    mismatches_o++;
  endtask

  task automatic clear_scan();
    scan_phase   = fqrl_pkg::PH_HEAD_SEARCH;
    prev_nl      = 1'b0;
    mark_set     = '0;
    qhead_len    = '0;
    record_given = 1'b0;
    for (int i = 0; i < fqrl_pkg::VX_N; i++) marks[i] = '0;
  endtask

  function automatic fqrl_pkg::pos_t mark_or_none(input int idx);
    return mark_set[idx] ? marks[idx] : '1;
  endfunction

  task automatic set_mark(input int idx, input fqrl_pkg::pos_t v);
    marks[idx]    = v;
    mark_set[idx] = 1'b1;
  endtask

  task automatic push_record(input fqrl_pkg::status_e st, input logic qe_ok,
                             input fqrl_pkg::pos_t qe);
    fqrl_pkg::result_t rec;
    rec.status = st;
    rec.hs     = mark_or_none(fqrl_pkg::VX_HS);
    rec.he     = mark_or_none(fqrl_pkg::VX_HE);
    rec.ss     = mark_or_none(fqrl_pkg::VX_SS);
    rec.se     = mark_or_none(fqrl_pkg::VX_SE);
    rec.qs     = mark_or_none(fqrl_pkg::VX_QS);
    rec.qe     = qe_ok ? qe : '1;
    expected_records.push_back(rec);
    record_given = 1'b1;
    scan_phase   = fqrl_pkg::PH_DONE;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic first, input logic last);
    fqrl_pkg::pos_t p;
    fqrl_pkg::pos_t hdr;
    fqrl_pkg::pos_t qe;
    logic           nl;
    nl = (b == fqrl_pkg::CHAR_NL);
    if (first) begin
      clear_scan();
      next_pos = fqrl_pkg::pos_t'(base_q);
    end
    p        = next_pos;
    next_pos = next_pos + 1;
    scanned_o++;
    if (record_given) return;
    case (scan_phase)
      fqrl_pkg::PH_HEAD_SEARCH: begin
        if (prev_nl && b == fqrl_pkg::CHAR_AT) begin
          set_mark(fqrl_pkg::VX_HS, p);
          scan_phase = fqrl_pkg::PH_HEAD_OPEN;
        end
        prev_nl = nl;
      end
      fqrl_pkg::PH_HEAD_OPEN: begin
        if (nl && !last) begin
          set_mark(fqrl_pkg::VX_HE, p);
          set_mark(fqrl_pkg::VX_SS, p + 1);
          scan_phase = fqrl_pkg::PH_SEQ_FIRST;
        end
      end
      fqrl_pkg::PH_SEQ_FIRST: begin
        prev_nl    = 1'b0;
        scan_phase = fqrl_pkg::PH_SEQ_OPEN;
      end
      fqrl_pkg::PH_SEQ_OPEN: begin
        if (prev_nl && b == fqrl_pkg::CHAR_PLUS) begin
          set_mark(fqrl_pkg::VX_SE, p - 1);
          scan_phase = fqrl_pkg::PH_QHEAD_OPEN;
          if (last) begin
            push_record(fqrl_pkg::ST_NO_QUAL_HEADER, 1'b0, '0);
            return;
          end
        end
        prev_nl = nl;
      end
      fqrl_pkg::PH_QHEAD_OPEN: begin
        if (nl && !last) begin
          qhead_len = p - marks[fqrl_pkg::VX_SE];
          hdr       = marks[fqrl_pkg::VX_HE] - marks[fqrl_pkg::VX_HS] + 1;
          // bare "+" line or same length as the header line
          if (fqrl_pkg::pos_t'(qhead_len - 1) > 1 && qhead_len != hdr) begin
            push_record(fqrl_pkg::ST_INVALID, 1'b0, '0);
            return;
          end
          set_mark(fqrl_pkg::VX_QS, p + 1);
          scan_phase = fqrl_pkg::PH_QUAL_WAIT;
        end
      end
      fqrl_pkg::PH_QUAL_WAIT: begin
        qe = marks[fqrl_pkg::VX_QS] + marks[fqrl_pkg::VX_SE] - marks[fqrl_pkg::VX_HE] - 1;
        if (p == fqrl_pkg::pos_t'(qe + 2)) begin
          push_record(fqrl_pkg::ST_COMPLETE, 1'b1, qe);
          return;
        end
      end
      default: return;
    endcase
    if (last) begin
      case (scan_phase)
        fqrl_pkg::PH_HEAD_SEARCH: push_record(fqrl_pkg::ST_NO_HEADER, 1'b0, '0);
        fqrl_pkg::PH_HEAD_OPEN:   push_record(fqrl_pkg::ST_HEADER_OPEN, 1'b0, '0);
        fqrl_pkg::PH_SEQ_FIRST,
        fqrl_pkg::PH_SEQ_OPEN:    push_record(fqrl_pkg::ST_SEQ_OPEN, 1'b0, '0);
        fqrl_pkg::PH_QHEAD_OPEN:  push_record(fqrl_pkg::ST_NO_QUAL_HEADER, 1'b0, '0);
        default:                  push_record(fqrl_pkg::ST_QUAL_SHORT, 1'b0, '0);
      endcase
    end
  endtask

  task automatic check_result();
    fqrl_pkg::result_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("unexpected record, status", {28'd0, status_i}, '0);
      return;
    end
    want = expected_records.pop_front();
    if (status_i !== want.status)
      report_mismatch("status", {28'd0, status_i}, {28'd0, want.status});
    if (header_start_i !== want.hs)   report_mismatch("header_start", header_start_i, want.hs);
    if (header_end_i !== want.he)     report_mismatch("header_end", header_end_i, want.he);
    if (sequence_start_i !== want.ss) report_mismatch("sequence_start", sequence_start_i, want.ss);
    if (sequence_end_i !== want.se)   report_mismatch("sequence_end", sequence_end_i, want.se);
    if (quality_start_i !== want.qs)  report_mismatch("quality_start", quality_start_i, want.qs);
    if (quality_end_i !== want.qe)    report_mismatch("quality_end", quality_end_i, want.qe);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   = '0;
      next_pos = '0;
      clear_scan();
      expected_records.delete();
      mismatches_o = 0;
      pending_o    = 0;
      scanned_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) base_q = base_offset_i;
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) scan_byte(data_byte_i, first_byte_i, last_byte_i);
      pending_o = expected_records.size();
    end
  end

endmodule

### bench/tb_fastq_record_locator_core.sv
// Testbench top for the FASTQ record locator: blob stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_fastq_record_locator_core;

  localparam int ITEMS          = 2000;
  localparam int CALM_AFTER     = 1700;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [fqrl_pkg::BASE_W-1:0] BASE_MAX = '1;

  logic                               clk_i;
  logic                               rst_ni        = 1'b0;
  logic                               in_valid_i    = 1'b0;
  logic                               in_stall_o;
  logic [7:0]                         data_byte_i   = '0;
  logic                               first_byte_i  = 1'b0;
  logic                               last_byte_i   = 1'b0;
  logic                               out_valid_o;
  logic                               out_stall_i   = 1'b0;
  logic [3:0]                         status_o;
  logic signed [fqrl_pkg::POS_W-1:0]  header_start_o;
  logic signed [fqrl_pkg::POS_W-1:0]  header_end_o;
  logic signed [fqrl_pkg::POS_W-1:0]  sequence_start_o;
  logic signed [fqrl_pkg::POS_W-1:0]  sequence_end_o;
  logic signed [fqrl_pkg::POS_W-1:0]  quality_start_o;
  logic signed [fqrl_pkg::POS_W-1:0]  quality_end_o;
  logic                               cfg_valid_i   = 1'b0;
  logic                               cfg_ready_o;
  logic [fqrl_pkg::BASE_W-1:0]        base_offset_i = '0;

  int         mismatches;
  int         pending;
  int         scanned;
  bit         calm       = 1'b0;
  int         stall_hold = 0;
  logic [7:0] blob_bytes [$];

  fastq_record_locator_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .header_start_o   (header_start_o),
    .header_end_o     (header_end_o),
    .sequence_start_o (sequence_start_o),
    .sequence_end_o   (sequence_end_o),
    .quality_start_o  (quality_start_o),
    .quality_end_o    (quality_end_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .base_offset_i    (base_offset_i)
  );

  fqrl_record_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_i         (status_o),
    .header_start_i   (header_start_o),
    .header_end_i     (header_end_o),
    .sequence_start_i (sequence_start_o),
    .sequence_end_i   (sequence_end_o),
    .quality_start_i  (quality_start_o),
    .quality_end_i    (quality_end_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .base_offset_i    (base_offset_i),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .scanned_o        (scanned)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random result-side stall bursts with random gaps between them, off once calm
  always @(posedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold  <= $urandom_range(0, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= $urandom_range(0, 16);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("fastq_record_locator_core test failed");
    $finish;
  end

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 255));
      4, 5:       return fqrl_pkg::CHAR_NL;
      6, 7:       return fqrl_pkg::CHAR_AT;
      default:    return fqrl_pkg::CHAR_PLUS;
    endcase
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] nucleotide();
    case ($urandom_range(0, 4))
      0:       return "A";
      1:       return "C";
      2:       return "G";
      3:       return "T";
      default: return "N";
    endcase
  endfunction

  function automatic logic [fqrl_pkg::BASE_W-1:0] pick_base();
    logic [fqrl_pkg::BASE_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = BASE_MAX;
      2:       v = fqrl_pkg::BASE_W'($urandom);
      default: v = fqrl_pkg::BASE_W'($urandom_range(0, 1000));
    endcase
    return v;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic first, input logic last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    first_byte_i <= first;
    last_byte_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [fqrl_pkg::BASE_W-1:0] v);
    quiesce();
    cfg_valid_i   <= 1'b1;
    base_offset_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_blob(input bit with_first, input bit with_last, input int cfg_at);
    for (int i = 0; i < blob_bytes.size(); i++) begin
      if (i == cfg_at) write_base(pick_base());
      put_byte(blob_bytes[i], with_first && i == 0, with_last && i == blob_bytes.size() - 1);
    end
  endtask

  task automatic build_record();
    logic [7:0] label [$];
    int         slen;
    slen = $urandom_range(0, 10);
    repeat ($urandom_range(0, 3)) blob_bytes.push_back(noise_byte());
    if ($urandom_range(0, 9) != 0) blob_bytes.push_back(fqrl_pkg::CHAR_NL);
    blob_bytes.push_back(fqrl_pkg::CHAR_AT);
    repeat ($urandom_range(0, 6)) label.push_back(printable());
    foreach (label[i]) blob_bytes.push_back(label[i]);
    blob_bytes.push_back(fqrl_pkg::CHAR_NL);
    repeat (slen) blob_bytes.push_back(nucleotide());
    blob_bytes.push_back(fqrl_pkg::CHAR_NL);
    blob_bytes.push_back(fqrl_pkg::CHAR_PLUS);
    case ($urandom_range(0, 5))
      0, 1, 2: ;
      3, 4:    foreach (label[i]) blob_bytes.push_back(label[i]);
      default: repeat ($urandom_range(1, 8)) blob_bytes.push_back(printable());
    endcase
    blob_bytes.push_back(fqrl_pkg::CHAR_NL);
    repeat (slen) blob_bytes.push_back(printable());
    blob_bytes.push_back(fqrl_pkg::CHAR_NL);
    repeat ($urandom_range(0, 4)) blob_bytes.push_back(noise_byte());
  endtask

  initial begin : stimulus
    int kind;
    int cut;
    int cfg_at;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // complete record straight after reset, positions from zero without a first byte
    blob_bytes = {8'h00, fqrl_pkg::CHAR_NL, fqrl_pkg::CHAR_AT, 8'hFF, fqrl_pkg::CHAR_NL,
                  "A", fqrl_pkg::CHAR_NL, fqrl_pkg::CHAR_PLUS, fqrl_pkg::CHAR_NL, "I",
                  fqrl_pkg::CHAR_NL, "x", "y"};
    send_blob(1'b0, 1'b1, -1);
    // '@' on the first byte is no start; '@' on the last byte leaves the header open
    blob_bytes = {fqrl_pkg::CHAR_AT, fqrl_pkg::CHAR_NL, fqrl_pkg::CHAR_AT};
    send_blob(1'b1, 1'b1, -1);
    // ignored: record already given
    blob_bytes = {fqrl_pkg::CHAR_NL};
    send_blob(1'b0, 1'b0, -1);
    // newline as first sequence byte, then '+' as the last byte
    blob_bytes = {fqrl_pkg::CHAR_NL, fqrl_pkg::CHAR_AT, "h", fqrl_pkg::CHAR_NL,
                  fqrl_pkg::CHAR_NL, fqrl_pkg::CHAR_PLUS, fqrl_pkg::CHAR_NL,
                  fqrl_pkg::CHAR_PLUS};
    send_blob(1'b1, 1'b1, -1);

    write_base(BASE_MAX);
    while (scanned < ITEMS) begin
      if (!calm && scanned >= CALM_AFTER) begin
        write_base('0);
        calm = 1'b1;
      end
      blob_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        build_record();
        if ($urandom_range(0, 2) == 0) build_record();
      end else begin
        repeat ($urandom_range(1, 24)) blob_bytes.push_back(noise_byte());
      end
      if (kind >= 55 && kind < 75) begin
        cut = $urandom_range(1, blob_bytes.size());
        while (blob_bytes.size() > cut) void'(blob_bytes.pop_back());
      end
      cfg_at = -1;
      if (!calm && blob_bytes.size() > 1 && $urandom_range(0, 9) == 0)
        cfg_at = $urandom_range(1, blob_bytes.size() - 1);
      send_blob($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0, cfg_at);
      if (!calm) begin
        if ($urandom_range(0, 7) == 0)
          write_base(pick_base());
        else if ($urandom_range(0, 9) == 0)
          quiesce();
      end
    end

    quiesce();
    if (mismatches == 0 && pending == 0)
      $display("fastq_record_locator_core test passed");
    else
      $display("fastq_record_locator_core test failed");
    $finish;
  end

endmodule

### files.f
hdl/fqrl_pkg.sv
hdl/fqrl_scan.sv
hdl/fastq_record_locator_core.sv
bench/fqrl_record_checker.sv
bench/tb_fastq_record_locator_core.sv
